FILE: hdl/lbcs_pkg.sv
// Package for the line block content selector: widths, character codes
// and default sizes shared by the top level, the front end and the back end.
// No dependencies.
package lbcs_pkg;

  // Default configuration of the block window and the length counter
  localparam int unsigned WINDOW_DEF      = 3;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned LNUM_W    = 24;
  localparam int unsigned OUT_LEN_W = 16;
  localparam int unsigned THR_W     = 18;

  // Depth of the line event queue between front and back
  localparam int unsigned EVQ_DEPTH = 4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HT  = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
  localparam logic [CHAR_W-1:0] CH_BEL = 8'd7;
  localparam logic [CHAR_W-1:0] CH_ESC = 8'd27;

  // True for the bytes that do not count towards a line length
  function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
    return (ch == CH_SP) || (ch == CH_HT) || (ch == CH_CR) ||
           (ch == CH_FF) || (ch == CH_BEL) || (ch == CH_ESC);
  endfunction

endpackage

FILE: hdl/line_block_content_selector.sv
// Top level of the line block content selector: threshold register,
// front end, line event queue and back end. Uses lbcs_pkg.
//
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_ready_o    char_code_i, end_of_text_i
//  result    out        out_valid_o / out_ready_i  line_number_o, line_length_o,
//                                                  is_content_o, final_line_o
//  config    in         surge_threshold_we_i       surge_threshold_i
//
// One byte is taken per cycle while the line event queue has room.
// A line event is taken from the queue into the window of pending lines; once
// the window is full, the oldest line is decided as a further line event is taken,
// while the output is free; at a stream end the pending lines (at most WINDOW+3) are decided in order.
// A stalled output holds the back end; the queue keeps the front running.
// Reset clears the open line, the pending window and the threshold.
module line_block_content_selector #(
  parameter int unsigned WINDOW      = lbcs_pkg::WINDOW_DEF,
  parameter int unsigned LENGTH_BITS = lbcs_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            surge_threshold_we_i,
  input  logic [lbcs_pkg::THR_W-1:0]      surge_threshold_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lbcs_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                            end_of_text_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lbcs_pkg::LNUM_W-1:0]     line_number_o,
  output logic [lbcs_pkg::OUT_LEN_W-1:0]  line_length_o,
  output logic                            is_content_o,
  output logic                            final_line_o
);

  localparam int unsigned EV_W = LENGTH_BITS + 2;

  logic [lbcs_pkg::THR_W-1:0] thr_q;
  logic                       ev_push, ev_full, ev_pop, ev_empty;
  logic [EV_W-1:0]            ev_wdata, ev_rdata;

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (surge_threshold_we_i) begin
      thr_q <= surge_threshold_i;
    end
  end

  lbcs_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .ev_push_o     (ev_push),
    .ev_data_o     (ev_wdata),
    .ev_full_i     (ev_full)
  );

  lbcs_fifo #(
    .WIDTH (EV_W),
    .DEPTH (lbcs_pkg::EVQ_DEPTH)
  ) u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .wdata_i (ev_wdata),
    .full_o  (ev_full),
    .pop_i   (ev_pop),
    .rdata_o (ev_rdata),
    .empty_o (ev_empty)
  );

  lbcs_back #(
    .WINDOW      (WINDOW),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .thr_i         (thr_q),
    .ev_empty_i    (ev_empty),
    .ev_data_i     (ev_rdata),
    .ev_pop_o      (ev_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_number_o (line_number_o),
    .line_length_o (line_length_o),
    .is_content_o  (is_content_o),
    .final_line_o  (final_line_o)
  );

endmodule

FILE: hdl/lbcs_fifo.sv
// Small first-in first-out queue of line events between front and back.
// Uses lbcs_pkg only through its parameters' callers; no submodules.
module lbcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/lbcs_front.sv
// Front end: takes text bytes, counts the non-blank bytes of the open line
// and pushes one event per finished line or end of text. Uses lbcs_pkg.
module lbcs_front #(
  parameter int unsigned LENGTH_BITS = lbcs_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lbcs_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                          end_of_text_i,
  output logic                          ev_push_o,
  output logic [LENGTH_BITS+1:0]        ev_data_o,
  input  logic                          ev_full_i
);

  typedef struct packed {
    logic                   is_line;
    logic                   eot;
    logic [LENGTH_BITS-1:0] len;
  } event_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic [LENGTH_BITS-1:0] cur_len_q, cur_len_d;
  logic                   accept, is_lf;
  event_t                 ev;

  assign in_ready_o = !ev_full_i;
  assign accept     = in_valid_i && !ev_full_i;
  assign is_lf      = (char_code_i == lbcs_pkg::CH_LF);

  // Classify the byte and build the line event
  always_comb begin
    ev.is_line = is_lf;
    ev.eot     = end_of_text_i;
    ev.len     = cur_len_q;
    cur_len_d  = cur_len_q;
    if (accept) begin
      if (is_lf || end_of_text_i) begin
        cur_len_d = '0;
      end else if (!lbcs_pkg::is_blank(char_code_i) && cur_len_q != LEN_MAX) begin
        cur_len_d = cur_len_q + 1'b1;
      end
    end
  end

  assign ev_push_o = accept && (is_lf || end_of_text_i);
  assign ev_data_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q <= '0;
    end else begin
      cur_len_q <= cur_len_d;
    end
  end

endmodule

FILE: hdl/lbcs_back.sv
// Back end: keeps the window of undecided lines, decides content per line
// and drives the output register. Uses lbcs_pkg; fed from lbcs_fifo.
module lbcs_back #(
  parameter int unsigned WINDOW      = lbcs_pkg::WINDOW_DEF,
  parameter int unsigned LENGTH_BITS = lbcs_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lbcs_pkg::THR_W-1:0]      thr_i,
  input  logic                            ev_empty_i,
  input  logic [LENGTH_BITS+1:0]          ev_data_i,
  output logic                            ev_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lbcs_pkg::LNUM_W-1:0]     line_number_o,
  output logic [lbcs_pkg::OUT_LEN_W-1:0]  line_length_o,
  output logic                            is_content_o,
  output logic                            final_line_o
);

  typedef struct packed {
    logic                   is_line;
    logic                   eot;
    logic [LENGTH_BITS-1:0] len;
  } event_t;

  localparam int unsigned PD    = WINDOW + 3;
  localparam int unsigned CNT_W = $clog2(PD + 1);
  localparam int unsigned SUM_W = LENGTH_BITS + $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = (SUM_W > lbcs_pkg::THR_W) ? SUM_W : lbcs_pkg::THR_W;

  event_t                        ev;
  logic [LENGTH_BITS-1:0]        pend_q [PD];
  logic [LENGTH_BITS-1:0]        view   [PD];
  logic [CNT_W-1:0]              cnt_q, vcnt;
  logic                          inc_q, inc_n, flush_q;
  logic [lbcs_pkg::LNUM_W-1:0]   lnum_q;
  logic [CMP_W-1:0]              blk [4];
  logic                          content, out_free;
  logic                          do_dec, do_store, end_stream, start_flush, is_final;

  logic                          out_valid_q;
  logic [lbcs_pkg::LNUM_W-1:0]   out_lnum_q;
  logic [lbcs_pkg::OUT_LEN_W-1:0] out_len_q;
  logic                          out_cont_q, out_final_q;

  assign ev       = ev_data_i;
  assign out_free = !out_valid_q || out_ready_i;

  // Window view: the pending lines with the incoming line appended
  always_comb begin
    for (int i = 0; i < PD; i++) begin
      view[i] = pend_q[i];
    end
    vcnt = cnt_q;
    if (!flush_q && !ev_empty_i && ev.is_line) begin
      for (int i = 0; i < PD; i++) begin
        if (CNT_W'(i) == cnt_q) begin
          view[i] = ev.len;
        end
      end
      vcnt = cnt_q + 1'b1;
    end
  end

  // Block sums at the four leading positions, zero where lines are missing
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      blk[j] = '0;
      if (CNT_W'(j + WINDOW) <= vcnt) begin
        for (int i = 0; i < WINDOW; i++) begin
          blk[j] = blk[j] + CMP_W'(view[j+i]);
        end
      end
    end
  end

  // Decide the oldest line
  always_comb begin
    content = 1'b0;
    inc_n   = 1'b0;
    if (!inc_q) begin
      content = (blk[0] > CMP_W'(thr_i)) && (blk[1] != '0) &&
                (blk[2] != '0) && (blk[3] != '0);
      inc_n   = content;
    end else if (CNT_W'(WINDOW) <= vcnt) begin
      content = 1'b1;
      inc_n   = !((blk[0] == '0) && (blk[1] == '0));
    end
  end

  // Sequence: append, decide, flush at end of text
  always_comb begin
    do_dec      = 1'b0;
    do_store    = 1'b0;
    end_stream  = 1'b0;
    start_flush = 1'b0;
    ev_pop_o    = 1'b0;
    is_final    = 1'b0;
    if (flush_q) begin
      do_dec   = out_free;
      is_final = (cnt_q == CNT_W'(1));
      end_stream = out_free && is_final;
    end else if (!ev_empty_i) begin
      if (ev.eot) begin
        ev_pop_o = 1'b1;
        if (vcnt == '0) begin
          end_stream = 1'b1;
        end else begin
          start_flush = 1'b1;
          do_store    = 1'b1;
        end
      end else if (vcnt == CNT_W'(PD)) begin
        do_dec   = out_free;
        ev_pop_o = out_free;
      end else begin
        ev_pop_o = 1'b1;
        do_store = 1'b1;
      end
    end
  end

  // Hold the window of pending lines
  always_ff @(posedge clk_i) begin
    if (do_dec) begin
      for (int i = 0; i < PD - 1; i++) begin
        pend_q[i] <= view[i+1];
      end
      pend_q[PD-1] <= '0;
    end else if (do_store) begin
      for (int i = 0; i < PD; i++) begin
        pend_q[i] <= view[i];
      end
    end
  end

  // Advance the line count and mode; return to reset at the end of a stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      inc_q   <= 1'b0;
      flush_q <= 1'b0;
      lnum_q  <= '0;
    end else if (end_stream) begin
      cnt_q   <= '0;
      inc_q   <= 1'b0;
      flush_q <= 1'b0;
      lnum_q  <= '0;
    end else begin
      if (do_dec) begin
        cnt_q  <= vcnt - 1'b1;
        inc_q  <= inc_n;
        lnum_q <= lnum_q + 1'b1;
      end else if (do_store) begin
        cnt_q <= vcnt;
      end
      if (start_flush) begin
        flush_q <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_dec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_dec) begin
      out_lnum_q  <= lnum_q;
      out_len_q   <= lbcs_pkg::OUT_LEN_W'(view[0]);
      out_cont_q  <= content;
      out_final_q <= is_final;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_number_o = out_lnum_q;
  assign line_length_o = out_len_q;
  assign is_content_o  = out_cont_q;
  assign final_line_o  = out_final_q;

endmodule

FILE: hdl/lbcs_checker.sv
// Port checker for the line block content selector, bound to the top level.
// Uses lbcs_pkg for field widths.
module lbcs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [lbcs_pkg::LNUM_W-1:0]     line_number_o,
  input logic [lbcs_pkg::OUT_LEN_W-1:0]  line_length_o,
  input logic                            is_content_o,
  input logic                            final_line_o
);

  logic [lbcs_pkg::LNUM_W-1:0] exp_lnum_q;

  // Track the line number the next request should carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_lnum_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_lnum_q <= final_line_o ? '0 : exp_lnum_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(line_number_o) && $stable(line_length_o) &&
      $stable(is_content_o) && $stable(final_line_o))
    else $error("result payload changed while stalled");

  a_lnum_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o == exp_lnum_q)
    else $error("line numbers out of sequence");

  a_last_not_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_line_o |-> !is_content_o)
    else $error("last line of a stream marked as content");

endmodule

bind line_block_content_selector lbcs_checker u_lbcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .line_number_o (line_number_o),
  .line_length_o (line_length_o),
  .is_content_o  (is_content_o),
  .final_line_o  (final_line_o)
);

FILE: dv/line_block_content_selector_test.sv
// Self-checking testbench for line_block_content_selector: streams text bytes,
// predicts every decided line and compares each result in order.
// Depends on lbcs_pkg and the line_block_content_selector RTL.
module line_block_content_selector_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes and character codes taken from the package
  localparam int unsigned WINDOW_DEF      = lbcs_pkg::WINDOW_DEF;
  localparam int unsigned LENGTH_BITS_DEF = lbcs_pkg::LENGTH_BITS_DEF;
  localparam int unsigned CHAR_W          = lbcs_pkg::CHAR_W;
  localparam int unsigned LNUM_W          = lbcs_pkg::LNUM_W;
  localparam int unsigned OUT_LEN_W       = lbcs_pkg::OUT_LEN_W;
  localparam int unsigned THR_W           = lbcs_pkg::THR_W;
  localparam logic [CHAR_W-1:0] CH_LF  = lbcs_pkg::CH_LF;
  localparam logic [CHAR_W-1:0] CH_SP  = lbcs_pkg::CH_SP;
  localparam logic [CHAR_W-1:0] CH_HT  = lbcs_pkg::CH_HT;
  localparam logic [CHAR_W-1:0] CH_CR  = lbcs_pkg::CH_CR;
  localparam logic [CHAR_W-1:0] CH_FF  = lbcs_pkg::CH_FF;
  localparam logic [CHAR_W-1:0] CH_BEL = lbcs_pkg::CH_BEL;
  localparam logic [CHAR_W-1:0] CH_ESC = lbcs_pkg::CH_ESC;

  localparam int unsigned PEND_DEPTH  = WINDOW_DEF + 3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 250;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam logic [OUT_LEN_W-1:0] LEN_MAX = OUT_LEN_W'((1 << LENGTH_BITS_DEF) - 1);
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eot;
  } text_byte_t;

  typedef struct packed {
    logic [LNUM_W-1:0]    number;
    logic [OUT_LEN_W-1:0] length;
    logic                 content;
    logic                 last;
  } line_verdict_t;

  logic                 clk_i;
  logic                 rst_ni               = 1'b0;
  logic                 surge_threshold_we_i = 1'b0;
  logic [THR_W-1:0]     surge_threshold_i    = '0;
  logic                 in_valid_i           = 1'b0;
  logic                 in_ready_o;
  logic [CHAR_W-1:0]    char_code_i          = '0;
  logic                 end_of_text_i        = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i          = 1'b0;
  logic [LNUM_W-1:0]    line_number_o;
  logic [OUT_LEN_W-1:0] line_length_o;
  logic                 is_content_o;
  logic                 final_line_o;

  line_block_content_selector i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .surge_threshold_we_i (surge_threshold_we_i),
    .surge_threshold_i    (surge_threshold_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .char_code_i          (char_code_i),
    .end_of_text_i        (end_of_text_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .line_number_o        (line_number_o),
    .line_length_o        (line_length_o),
    .is_content_o         (is_content_o),
    .final_line_o         (final_line_o)
  );

  // Byte requests waiting to be sent and line verdicts waiting to arrive
  text_byte_t    text_q[$];
  line_verdict_t verdict_q[$];

  // Shadow of the selector state
  logic [THR_W-1:0]     shadow_thr;
  logic [OUT_LEN_W-1:0] open_len;
  logic [OUT_LEN_W-1:0] window_len[PEND_DEPTH];
  int unsigned          window_cnt;
  logic                 body_mode;
  logic [LNUM_W-1:0]    oldest_lnum;

  // Handshake bookkeeping shared between the posedge and negedge processes
  bit          byte_taken;
  bit          verdict_taken;
  int unsigned send_idle_max;
  int unsigned recv_idle_max;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_token;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned random_bytes;

  logic [CHAR_W-1:0] blank_codes[6] = '{CH_SP, CH_HT, CH_CR, CH_FF, CH_BEL, CH_ESC};
  int unsigned       idle_pick[3]   = '{0, 3, 15};

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Line selection prediction
  // ---------------------------------------------------------------------

  function automatic logic [THR_W+1:0] window_sum(input int unsigned first);
    logic [THR_W+1:0] acc;
    acc = '0;
    if (first + WINDOW_DEF > window_cnt) return '0;
    for (int unsigned i = 0; i < WINDOW_DEF; i++) acc += window_len[first+i];
    return acc;
  endfunction

  function automatic void clear_text_state();
    open_len    = '0;
    for (int unsigned i = 0; i < PEND_DEPTH; i++) window_len[i] = '0;
    window_cnt  = 0;
    body_mode   = 1'b0;
    oldest_lnum = '0;
  endfunction

  // Decide the oldest pending line and queue its verdict
  function automatic void decide_oldest_line(input logic last);
    logic          body;
    line_verdict_t v;
    if (!body_mode) begin
      body = (window_sum(0) > shadow_thr) && (window_sum(1) != 0) &&
             (window_sum(2) != 0) && (window_sum(3) != 0);
      body_mode = body;
    end else if (window_cnt >= WINDOW_DEF) begin
      body = 1'b1;
      if (window_sum(0) == 0 && window_sum(1) == 0) body_mode = 1'b0;
    end else begin
      body      = 1'b0;
      body_mode = 1'b0;
    end
    v = '{number: oldest_lnum, length: window_len[0], content: body, last: last};
    verdict_q.insert(verdict_q.size(), v);
    for (int unsigned i = 1; i < window_cnt; i++) window_len[i-1] = window_len[i];
    window_len[window_cnt-1] = '0;
    window_cnt--;
    oldest_lnum++;
  endfunction

  function automatic void absorb_byte(input logic [CHAR_W-1:0] code, input logic eot);
    if (code == CH_LF) begin
      if (window_cnt < PEND_DEPTH) begin
        window_len[window_cnt] = open_len;
        window_cnt++;
      end
      open_len = '0;
      if (window_cnt == PEND_DEPTH && !eot) decide_oldest_line(1'b0);
    end else if (!(code inside {CH_SP, CH_HT, CH_CR, CH_FF, CH_BEL, CH_ESC})) begin
      if (open_len < LEN_MAX) open_len++;
    end
    if (eot) begin
      while (window_cnt > 0) decide_oldest_line(window_cnt == 1);
      clear_text_state();
    end
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("%0t ns: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Sender and receiver
  // ---------------------------------------------------------------------

  // Predict each accepted request and check each delivered line
  always @(posedge clk_i) begin
    line_verdict_t exp_v;
    if (rst_ni && in_valid_i && in_ready_o) begin
      absorb_byte(char_code_i, end_of_text_i);
      byte_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      verdict_taken = 1'b1;
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("unexpected line %0d length %0d content %0b final %0b",
                             line_number_o, line_length_o, is_content_o, final_line_o));
      end else begin
        exp_v = verdict_q.pop_front();
        if (line_number_o !== exp_v.number || line_length_o !== exp_v.length ||
            is_content_o !== exp_v.content || final_line_o !== exp_v.last) begin
          flag_error($sformatf({"line mismatch: expected %0d/%0d/%0b/%0b, ",
                                "got %0d/%0d/%0b/%0b (number/length/content/final)"},
                               exp_v.number, exp_v.length, exp_v.content, exp_v.last,
                               line_number_o, line_length_o, is_content_o, final_line_o));
        end
      end
    end
  end

  // Drive byte requests: hold each until taken, then idle for a drawn gap
  always @(negedge clk_i) begin
    logic       nv;
    text_byte_t b;
    nv = in_valid_i;
    if (byte_taken) begin
      byte_taken = 1'b0;
      nv         = 1'b0;
      send_gap   = $urandom_range(0, send_idle_max);
    end
    if (!nv) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (text_q.size() != 0) begin
        b = text_q.pop_front();
        char_code_i   <= b.code;
        end_of_text_i <= b.eot;
        nv = 1'b1;
      end
    end
    in_valid_i <= nv;
  end

  // Accept line requests, stalling for a drawn gap or a long hold-off
  always @(negedge clk_i) begin
    logic nr;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (verdict_taken) begin
      verdict_taken = 1'b0;
      recv_gap      = $urandom_range(0, recv_idle_max);
    end
    if (hold_left != 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    out_ready_i <= nr;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic void push_byte(input logic [CHAR_W-1:0] code, input logic eot);
    text_byte_t b;
    b.code = code;
    b.eot  = eot;
    text_q.insert(text_q.size(), b);
    random_bytes++;
  endfunction

  // Queue one stream of lines with random text, ended in one of three ways
  function automatic void queue_stream(input int unsigned n_lines);
    int unsigned n_bytes;
    for (int unsigned l = 0; l < n_lines; l++) begin
      n_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
      for (int unsigned k = 0; k < n_bytes; k++) begin
        case ($urandom_range(0, 9))
          0, 1:    push_byte(blank_codes[$urandom_range(0, 5)], 1'b0);
          2:       push_byte(8'($urandom_range(0, 255)), 1'b0);
          default: push_byte(8'($urandom_range(33, 126)), 1'b0);
        endcase
      end
      push_byte(CH_LF, 1'b0);
    end
    case ($urandom_range(0, 2))
      0: begin
        // end of text on the last LF, or on a lone LF
        if (text_q.size() != 0 && n_lines != 0) text_q[$].eot = 1'b1;
        else push_byte(CH_LF, 1'b1);
      end
      1: begin
        // trailing unterminated line is dropped
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(33, 255)), 1'b0);
        push_byte(8'($urandom_range(33, 255)), 1'b1);
      end
      default: push_byte(blank_codes[$urandom_range(0, 5)], 1'b1);
    endcase
  endfunction

  function automatic logic [THR_W-1:0] THR_WL(input int unsigned value);
    return THR_W'(value);
  endfunction

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk_i);
    surge_threshold_we_i <= 1'b1;
    surge_threshold_i    <= value;
    shadow_thr = value;
    @(negedge clk_i);
    surge_threshold_we_i <= 1'b0;
  endtask

  // Wait for all requests to drain, then cover the flush latency
  task automatic wait_idle();
    do @(posedge clk_i);
    while (text_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
    repeat (2 * PEND_DEPTH + 8) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    logic [THR_W-1:0] thr;
    shadow_thr = '0;
    clear_text_state();
    send_idle_max = 0;
    recv_idle_max = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty stream, every blank, NUL/VT/0xFF counted, trailing drop
    write_threshold('0);
    push_byte(8'h41, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h0B, 1'b0);
    foreach (blank_codes[i]) push_byte(blank_codes[i], 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_LF, 1'b0);
    for (int unsigned i = 0; i < 3; i++) begin
      push_byte(8'h79, 1'b0);
      push_byte(CH_LF, 1'b0);
    end
    push_byte(8'h76, 1'b0);
    push_byte(CH_LF, 1'b1);
    wait_idle();

    // Random streams across several thresholds and idle patterns
    phase = 0;
    while (random_bytes < RANDOM_BYTES) begin
      case (phase)
        0:       thr = THR_MAX;
        1:       thr = THR_WL(1);
        2:       thr = THR_WL(12);
        default: thr = ($urandom_range(0, 3) == 0) ? THR_WL($urandom_range(0, 262143))
                                                   : THR_WL($urandom_range(0, 40));
      endcase
      write_threshold(thr);
      if (phase == 0) begin
        // Stall the receiver while bytes keep coming, to fill the block
        send_idle_max = 0;
        recv_idle_max = 0;
        hold_token++;
        queue_stream(16);
      end
      repeat ($urandom_range(1, 3)) begin
        send_idle_max = idle_pick[$urandom_range(0, 2)];
        recv_idle_max = idle_pick[$urandom_range(0, 2)];
        queue_stream(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(3, 16));
        do @(negedge clk_i);
        while (text_q.size() > 2);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lbcs_pkg.sv
hdl/lbcs_fifo.sv
hdl/lbcs_front.sv
hdl/lbcs_back.sv
hdl/line_block_content_selector.sv
hdl/lbcs_checker.sv
dv/line_block_content_selector_test.sv
